>>> rtl/stable_quadratic_root_solver_top_assert.svh
// Assertion macros for the stable quadratic root solver.
// Needs clk and rst in the scope where a macro is used; no other dependencies.
`ifndef STABLE_QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define STABLE_QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SQRS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define SQRS_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SQRS_ASSERT(name, prop)
`define SQRS_ASSERT_RST(name, prop)
`endif
`endif

>>> rtl/sqrs_pkg.sv
// Shared types of the stable quadratic root solver.
// No dependencies; used by the root interface, the top level and the testbench.
package sqrs_pkg;

  typedef enum logic [1:0] {
    ST_TWO_ROOTS  = 2'd0,
    ST_NEG_DISC   = 2'd1,
    ST_LINEAR     = 2'd2,
    ST_DEGENERATE = 2'd3
  } status_t;

endpackage

>>> rtl/sqrs_coef_if.sv
// Valid/ready channel carrying one set of coefficients a, b and c.
// Depends on nothing.
interface sqrs_coef_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] coef_a;
  logic signed [WORD_BITS-1:0] coef_b;
  logic signed [WORD_BITS-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

>>> rtl/sqrs_root_if.sv
// Valid/ready channel carrying the two roots and the status code.
// Depends on sqrs_pkg for the status type.
interface sqrs_root_if import sqrs_pkg::*; #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] root_first;
  logic signed [WORD_BITS-1:0] root_second;
  status_t                     status;

  modport source (output valid, root_first, root_second, status, input ready);
  modport sink (input valid, root_first, root_second, status, output ready);
endinterface

>>> rtl/stable_quadratic_root_solver_top.sv
// Stable quadratic root solver for signed fixed-point words (Q16.16 with the default parameters).
// Throughput one item per cycle; the pipeline moves as one and only halts when
// the output register holds an item that has not been taken.
// The latency is set by the square root (one root bit per stage) and the two
// parallel dividers (one quotient bit per stage).
// Synchronous reset clears every valid bit; the data registers are not reset.
module stable_quadratic_root_solver_top import sqrs_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  sqrs_coef_if.sink    coef,
  sqrs_root_if.source  root
);

`include "stable_quadratic_root_solver_top_assert.svh"

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int H   = (W + 1) / 2;   // low half of a magnitude for the partial products
  localparam int PPW = 2 * H;         // partial product width
  localparam int PW  = 2 * W;         // full product width
  localparam int DW  = 2 * W + 2;     // discriminant width, 4ac included
  localparam int NS  = W + 1;         // root bits, one per square-root stage
  localparam int RMW = NS + 2;        // square-root remainder width
  localparam int DN  = W + 2;         // divisor width
  localparam int NQ  = W + F + 2;     // dividend width, one per divider stage

  // Side data that travels with an item up to the end of the square root.
  typedef struct packed {
    logic          na;
    logic          nb;
    logic          nc;
    logic          za;
    logic          zb;
    logic [W-1:0]  ma;
    logic [W-1:0]  mb;
    logic [W-1:0]  mc;
    status_t       status;
  } side_t;

  // Side data that travels with an item through the dividers.
  typedef struct packed {
    status_t     status;
    logic        bpos;
    logic        zero0;
    logic [1:0]  neg;
  } dside_t;

  // The whole pipeline advances when the output register is empty or being taken.
  logic en;
  logic o_vld;
  assign en = !o_vld || root.ready;
  assign coef.ready = en;

  // Stage 1: input register.
  logic                v1;
  logic [W-1:0]        r1_a, r1_b, r1_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= coef.valid;
    end
    if (en) begin
      r1_a <= coef.coef_a;
      r1_b <= coef.coef_b;
      r1_c <= coef.coef_c;
    end
  end

  // Stage 2: signs and magnitudes. The most negative code gives a magnitude
  // of 2^(W-1), which still fits the unsigned word.
  logic   v2;
  side_t  s2_side;
  side_t  s2_next;

  always_comb begin
    s2_next        = '0;
    s2_next.na     = r1_a[W-1];
    s2_next.nb     = r1_b[W-1];
    s2_next.nc     = r1_c[W-1];
    s2_next.ma     = r1_a[W-1] ? (~r1_a + W'(1)) : r1_a;
    s2_next.mb     = r1_b[W-1] ? (~r1_b + W'(1)) : r1_b;
    s2_next.mc     = r1_c[W-1] ? (~r1_c + W'(1)) : r1_c;
    s2_next.za     = (r1_a == '0);
    s2_next.zb     = (r1_b == '0);
    s2_next.status = ST_TWO_ROOTS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      s2_side <= s2_next;
    end
  end

  // Stage 3: half-word partial products of b*b and a*c.
  logic            v3;
  side_t           s3_side;
  logic [PPW-1:0]  s3_pb [4];
  logic [PPW-1:0]  s3_pc [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      s3_side  <= s2_side;
      s3_pb[0] <= s2_side.mb[H-1:0] * s2_side.mb[H-1:0];
      s3_pb[1] <= s2_side.mb[H-1:0] * s2_side.mb[W-1:H];
      s3_pb[2] <= s2_side.mb[W-1:H] * s2_side.mb[H-1:0];
      s3_pb[3] <= s2_side.mb[W-1:H] * s2_side.mb[W-1:H];
      s3_pc[0] <= s2_side.ma[H-1:0] * s2_side.mc[H-1:0];
      s3_pc[1] <= s2_side.ma[H-1:0] * s2_side.mc[W-1:H];
      s3_pc[2] <= s2_side.ma[W-1:H] * s2_side.mc[H-1:0];
      s3_pc[3] <= s2_side.ma[W-1:H] * s2_side.mc[W-1:H];
    end
  end

  // Stage 4: b*b and 4ac assembled from the partial products.
  logic           v4;
  side_t          s4_side;
  logic [PW-1:0]  s4_p;
  logic [DW-1:0]  s4_r;
  logic [PW-1:0]  p_sum, ac_sum;

  assign p_sum  = (PW'(s3_pb[3]) << (2 * H)) + ((PW'(s3_pb[1]) + PW'(s3_pb[2])) << H)
                + PW'(s3_pb[0]);
  assign ac_sum = (PW'(s3_pc[3]) << (2 * H)) + ((PW'(s3_pc[1]) + PW'(s3_pc[2])) << H)
                + PW'(s3_pc[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      s4_side <= s3_side;
      s4_p    <= p_sum;
      s4_r    <= DW'(ac_sum) << 2;
    end
  end

  // Stage 5: status and discriminant, loaded into the head of the square root.
  // Opposite signs of a and c make 4ac add; equal signs subtract it, and a
  // negative result is flagged before it is formed.
  logic [DW-1:0]  d5;
  status_t        st5;
  side_t          sq_head;

  always_comb begin
    d5  = '0;
    st5 = ST_TWO_ROOTS;
    if (s4_side.za) begin
      st5 = s4_side.zb ? ST_DEGENERATE : ST_LINEAR;
    end else if (s4_side.na != s4_side.nc) begin
      d5 = DW'(s4_p) + s4_r;
    end else if (s4_r > DW'(s4_p)) begin
      st5 = ST_NEG_DISC;
    end else begin
      d5 = DW'(s4_p) - s4_r;
    end
    sq_head        = s4_side;
    sq_head.status = st5;
  end

  // Square root: one root bit per stage, restoring digit-by-digit method.
  logic [NS:0]     sq_vld;
  logic [RMW-1:0]  sq_rem  [0:NS];
  logic [NS-1:0]   sq_root [0:NS];
  logic [DW-1:0]   sq_rad  [0:NS];
  side_t           sq_side [0:NS];
  logic [RMW+1:0]  sq_cur  [0:NS-1];
  logic [RMW+1:0]  sq_trl  [0:NS-1];

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      sq_cur[k] = {sq_rem[k], sq_rad[k][DW-1 -: 2]};
      sq_trl[k] = (RMW + 2)'({sq_root[k], 2'b01});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= '0;
    end else if (en) begin
      sq_vld <= {sq_vld[NS-1:0], v4};
    end
    if (en) begin
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_rad[0]  <= d5;
      sq_side[0] <= sq_head;
      for (int k = 0; k < NS; k++) begin
        if (sq_cur[k] >= sq_trl[k]) begin
          sq_rem[k+1]  <= RMW'(sq_cur[k] - sq_trl[k]);
          sq_root[k+1] <= {sq_root[k][NS-2:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= RMW'(sq_cur[k]);
          sq_root[k+1] <= {sq_root[k][NS-2:0], 1'b0};
        end
        sq_rad[k+1]  <= sq_rad[k] << 2;
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // Set-up stage: q = |b| + S, divider operands and result signs.
  // Lane 0 forms 2c/q (or c/b for a zero a), lane 1 forms q/(2a).
  // With b positive q is negative, otherwise q is non-negative.
  side_t          su_side;
  logic [DN-1:0]  su_mq;
  logic           su_bpos;
  logic           su_zc;
  dside_t         su_ds;
  logic [NQ-1:0]  su_num [2];
  logic [DN-1:0]  su_den [2];

  always_comb begin
    su_side   = sq_side[NS];
    su_mq     = DN'(su_side.mb) + DN'(sq_root[NS]);
    su_bpos   = !su_side.nb && (su_side.mb != '0);
    su_zc     = (su_side.mc == '0);
    su_ds        = '0;
    su_ds.status = su_side.status;
    su_ds.bpos   = su_bpos;
    su_num[1]    = NQ'(su_mq) << F;
    su_den[1]    = DN'({su_side.ma, 1'b0});
    if (su_side.status == ST_LINEAR) begin
      su_ds.neg[0] = (su_side.nb == su_side.nc) && !su_zc;
      su_num[0]    = NQ'(su_side.mc) << F;
      su_den[0]    = DN'(su_side.mb);
    end else begin
      su_ds.neg[0] = (su_side.nc != su_bpos) && !su_zc;
      su_ds.neg[1] = (su_bpos != su_side.na) && (su_mq != '0);
      su_ds.zero0  = (su_mq == '0);
      su_num[0]    = NQ'(su_side.mc) << (F + 1);
      su_den[0]    = su_mq;
    end
  end

  // Dividers: two lanes side by side, one quotient bit per stage.
  logic [NQ:0]    dv_vld;
  dside_t         dv_side [0:NQ];
  logic [DN-1:0]  dv_rem  [0:NQ][2];
  logic [NQ-1:0]  dv_num  [0:NQ][2];
  logic [NQ-1:0]  dv_q    [0:NQ][2];
  logic [DN-1:0]  dv_den  [0:NQ][2];
  logic [DN:0]    dv_cur  [0:NQ-1][2];
  logic           dv_ge   [0:NQ-1][2];

  always_comb begin
    for (int k = 0; k < NQ; k++) begin
      for (int l = 0; l < 2; l++) begin
        dv_cur[k][l] = {dv_rem[k][l], dv_num[k][l][NQ-1]};
        dv_ge[k][l]  = (dv_cur[k][l] >= {1'b0, dv_den[k][l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld <= '0;
    end else if (en) begin
      dv_vld <= {dv_vld[NQ-1:0], sq_vld[NS]};
    end
    if (en) begin
      dv_side[0] <= su_ds;
      for (int l = 0; l < 2; l++) begin
        dv_rem[0][l] <= '0;
        dv_num[0][l] <= su_num[l];
        dv_q[0][l]   <= '0;
        dv_den[0][l] <= su_den[l];
      end
      for (int k = 0; k < NQ; k++) begin
        dv_side[k+1] <= dv_side[k];
        for (int l = 0; l < 2; l++) begin
          dv_rem[k+1][l] <= dv_ge[k][l] ? DN'(dv_cur[k][l] - {1'b0, dv_den[k][l]})
                                        : DN'(dv_cur[k][l]);
          dv_num[k+1][l] <= dv_num[k][l] << 1;
          dv_q[k+1][l]   <= {dv_q[k][l][NQ-2:0], dv_ge[k][l]};
          dv_den[k+1][l] <= dv_den[k][l];
        end
      end
    end
  end

  // Output stage: sign, saturation to the word range and root ordering.
  localparam logic [NQ-1:0] LIM = NQ'(1) << (W - 1);

  dside_t         fn_side;
  logic [NQ-1:0]  fn_v   [2];
  logic [W-1:0]   fn_enc [2];
  logic [W-1:0]   fn_first, fn_second;

  always_comb begin
    fn_side = dv_side[NQ];
    for (int l = 0; l < 2; l++) begin
      if (fn_side.neg[l]) begin
        fn_v[l]   = (dv_q[NQ][l] > LIM) ? LIM : dv_q[NQ][l];
        fn_enc[l] = ~fn_v[l][W-1:0] + W'(1);
      end else begin
        fn_v[l]   = (dv_q[NQ][l] > LIM - NQ'(1)) ? LIM - NQ'(1) : dv_q[NQ][l];
        fn_enc[l] = fn_v[l][W-1:0];
      end
    end
    if (fn_side.zero0) begin
      fn_enc[0] = '0;
    end
    fn_first  = '0;
    fn_second = '0;
    case (fn_side.status)
      ST_TWO_ROOTS: begin
        fn_first  = fn_side.bpos ? fn_enc[0] : fn_enc[1];
        fn_second = fn_side.bpos ? fn_enc[1] : fn_enc[0];
      end
      ST_LINEAR: begin
        fn_first = fn_enc[0];
      end
      default: begin
        fn_first  = '0;
        fn_second = '0;
      end
    endcase
  end

  logic [W-1:0]  o_first, o_second;
  status_t       o_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= dv_vld[NQ];
    end
    if (en) begin
      o_first  <= fn_first;
      o_second <= fn_second;
      o_status <= fn_side.status;
    end
  end

  assign root.valid       = o_vld;
  assign root.root_first  = o_first;
  assign root.root_second = o_second;
  assign root.status      = o_status;

  `SQRS_ASSERT(a_neg_disc_zero, (o_vld && o_status == ST_NEG_DISC) |-> (o_first == '0))
  `SQRS_ASSERT(a_degenerate_zero, (o_vld && o_status == ST_DEGENERATE) |-> (o_first == '0))
  `SQRS_ASSERT(a_single_root, (o_vld && o_status != ST_TWO_ROOTS) |-> (o_second == '0))
  `SQRS_ASSERT(a_stall_holds, !en |=> ($stable(sq_vld) && $stable(dv_vld) && $stable(o_vld)))
  `SQRS_ASSERT_RST(a_reset_empty, rst |=> (!o_vld && sq_vld == '0 && dv_vld == '0))

endmodule

>>> sim/tb_stable_quadratic_root_solver_top.sv
// Self-checking testbench for the stable quadratic root solver top level.
// Depends on sqrs_pkg, sqrs_coef_if, sqrs_root_if and the RTL top module.

import sqrs_pkg::*;

// Holds the roots predicted for every accepted coefficient set, oldest first,
// and compares each delivered result against the head of that queue.
class root_scoreboard;
  typedef struct {
    logic signed [31:0] first;
    logic signed [31:0] second;
    status_t            status;
  } root_set_t;

  root_set_t pending_roots[$];
  int        fail_count;

  function new();
    fail_count = 0;
  endfunction

  // Signed word to sign flag and magnitude; the most negative word keeps 2^31.
  function automatic void split_word(input logic [31:0] raw, output bit neg,
                                     output logic [32:0] mag);
    neg = raw[31];
    mag = neg ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
  endfunction

  function automatic logic [31:0] saturate(input bit neg, input logic [127:0] mag);
    logic [127:0] lim;
    logic [127:0] v;
    lim = 128'h8000_0000;
    if (neg) begin
      v = (mag > lim) ? lim : mag;
      return 32'(-v);
    end
    v = (mag > lim - 1) ? lim - 1 : mag;
    return v[31:0];
  endfunction

  function automatic logic [31:0] trunc_div(input bit neg, input logic [127:0] num,
                                            input logic [127:0] den);
    if (den == 0) return 32'd0;
    return saturate(neg, num / den);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
    logic [63:0]  res;
    logic [63:0]  t;
    logic [127:0] sq;
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      t = res | (64'd1 << i);
      sq = 128'(t) * 128'(t);
      if (sq <= n) res = t;
    end
    return res;
  endfunction

  function automatic root_set_t solve_roots(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
    root_set_t    r;
    bit           na, nb, nc, nq, b_pos;
    logic [32:0]  ma, mb, mc;
    logic [127:0] sq_b, four_ac, disc, mq;
    logic [31:0]  lin, quad;
    split_word(a, na, ma);
    split_word(b, nb, mb);
    split_word(c, nc, mc);
    r.first = '0;
    r.second = '0;
    r.status = ST_TWO_ROOTS;
    if (ma == 0) begin
      if (mb == 0) begin
        r.status = ST_DEGENERATE;
      end else begin
        // Linear root -c/b: negative when b and c share a sign.
        r.first = trunc_div((nb == nc) && mc != 0, 128'(mc) << 16, 128'(mb));
        r.status = ST_LINEAR;
      end
      return r;
    end
    sq_b = 128'(mb) * 128'(mb);
    four_ac = (128'(ma) * 128'(mc)) << 2;
    if (na != nc) begin
      disc = sq_b + four_ac;
    end else begin
      if (four_ac > sq_b) begin
        r.status = ST_NEG_DISC;
        return r;
      end
      disc = sq_b - four_ac;
    end
    mq = 128'(mb) + 128'(floor_sqrt(disc));
    b_pos = !nb && mb != 0;
    nq = b_pos && mq != 0;
    lin = (mq == 0) ? 32'd0 : trunc_div((nc != nq) && mc != 0, 128'(mc) << 17, mq);
    quad = trunc_div((nq != na) && mq != 0, mq << 16, 128'(ma) << 1);
    if (b_pos) begin
      r.first = lin;
      r.second = quad;
    end else begin
      r.first = quad;
      r.second = lin;
    end
    return r;
  endfunction

  function void note_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    pending_roots.push_back(solve_roots(a, b, c));
  endfunction

  function void check_roots(input logic [31:0] first, input logic [31:0] second,
                            input status_t status);
    root_set_t e;
    if (pending_roots.size() == 0) begin
      $error("root item delivered with nothing outstanding");
      fail_count++;
      return;
    end
    e = pending_roots.pop_front();
    if (status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, status);
      fail_count++;
    end
    if (first !== e.first) begin
      $error("root_first: expected %0d, got %0d", e.first, $signed(first));
      fail_count++;
    end
    if (second !== e.second) begin
      $error("root_second: expected %0d, got %0d", e.second, $signed(second));
      fail_count++;
    end
  endfunction
endclass

module tb_stable_quadratic_root_solver_top;

  // Depth of the pipeline for Q16.16.
  localparam int PIPE_DEPTH = 90;
  localparam int RANDOM_ITEMS = 1700;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sqrs_coef_if #(.WORD_BITS(32)) coef_ch ();
  sqrs_root_if #(.WORD_BITS(32)) root_ch ();

  stable_quadratic_root_solver_top #(
    .WORD_BITS(32),
    .FRAC_BITS(16)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .coef (coef_ch),
    .root (root_ch)
  );

  root_scoreboard roots_sb = new();

  // When set, idling is switched off on both sides for a stretch of items.
  bit steady_flow = 1'b0;
  // Asks the receiver to hold off for a long stretch so the pipeline backs up.
  bit hold_request = 1'b0;

  always #1 clk = ~clk;

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one coefficient set after an optional idle gap and waits until it is taken.
  // The valid line is only lowered when a gap is wanted, so back-to-back items keep it high.
  task automatic offer_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      coef_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coef_ch.valid <= 1'b1;
    coef_ch.coef_a <= a;
    coef_ch.coef_b <= b;
    coef_ch.coef_c <= c;
    do @(posedge clk); while (!(coef_ch.valid && coef_ch.ready));
    roots_sb.note_coefs(a, b, c);
  endtask

  // Waits until every predicted result has been delivered, with nothing offered.
  task automatic drain_results();
    coef_ch.valid <= 1'b0;
    while (roots_sb.pending_roots.size() != 0) @(posedge clk);
  endtask

  // Draws a random coefficient with a spread of magnitudes, so that the
  // discriminant is often non-negative and the division results stay in range,
  // while plain full-width words still exercise every bit.
  function automatic logic [31:0] random_coef();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 32'h0000_ffff);
      2: v = $urandom_range(0, 32'h00ff_ffff);
      3: v = $urandom_range(0, 32'h0fff_ffff);
      4: v = 32'($urandom_range(0, 8)) << 16;
      default: v = $urandom_range(0, 255);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Receiver: stalls a random number of cycles before each item, or for a long
  // stretch when asked, and checks every item it takes.
  initial begin
    int stall;
    root_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        root_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 13);
        if (stall > 0) begin
          root_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      root_ch.ready <= 1'b1;
      do @(posedge clk); while (!(root_ch.valid && root_ch.ready));
      roots_sb.check_roots(root_ch.root_first, root_ch.root_second, root_ch.status);
    end
  end

  // Sender: reset, a directed set of corner cases, then random items.
  initial begin
    logic [31:0] a, b, c;
    coef_ch.valid <= 1'b0;
    coef_ch.coef_a <= '0;
    coef_ch.coef_b <= '0;
    coef_ch.coef_c <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // a and b both zero, with and without a constant.
    offer_coefs(32'd0, 32'd0, 32'd0);
    offer_coefs(32'd0, 32'd0, 32'h8000_0000);
    // a zero: linear root, for three of the four pairings of signs and at the extremes.
    offer_coefs(32'd0, 32'h0002_0000, 32'h0004_0000);
    offer_coefs(32'd0, 32'hfffe_0000, 32'h0004_0000);
    offer_coefs(32'd0, 32'h0000_0001, 32'h7fff_ffff);
    offer_coefs(32'd0, 32'h8000_0000, 32'h8000_0000);
    offer_coefs(32'd0, 32'h0001_0000, 32'd0);
    // Negative discriminant: same signs of a and c with a small b.
    offer_coefs(32'h0001_0000, 32'd0, 32'h0001_0000);
    offer_coefs(32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
    // Two roots with b positive, negative and zero.
    offer_coefs(32'h0001_0000, 32'h0003_0000, 32'h0002_0000);
    offer_coefs(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
    offer_coefs(32'h0001_0000, 32'd0, 32'hfffc_0000);
    // Zero q: b and c both zero.
    offer_coefs(32'h0002_0000, 32'd0, 32'd0);
    offer_coefs(32'h8000_0000, 32'd0, 32'd0);
    // Extreme words everywhere, and saturation from a tiny a.
    offer_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    offer_coefs(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    offer_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    offer_coefs(32'h0000_0001, 32'h7fff_ffff, 32'hffff_ffff);
    offer_coefs(32'hffff_ffff, 32'h8000_0000, 32'h0000_0001);
    offer_coefs(32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Stretches of items with no idling on either side.
      if (i % 200 == 100) steady_flow = 1'b1;
      if (i % 200 == 160) steady_flow = 1'b0;
      // Back up the pipeline once while the sender keeps offering.
      if (i == 400) hold_request = 1'b1;
      // Let the pipeline empty completely once before carrying on.
      if (i == 900) drain_results();
      a = random_coef();
      b = random_coef();
      c = random_coef();
      if ($urandom_range(0, 15) == 0) a = '0;
      if ($urandom_range(0, 31) == 0) b = '0;
      if ($urandom_range(0, 31) == 0) c = '0;
      offer_coefs(a, b, c);
    end
    coef_ch.valid <= 1'b0;

    drain_results();
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (roots_sb.fail_count == 0 && roots_sb.pending_roots.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
